@@ design/lpmd_pkg.sv @@
`default_nettype none
package lpmd_pkg;

	// Frame limits and size rules
	localparam logic [20:0] LIMIT_CAP      = 21'd1048576;
	localparam logic [20:0] REQUEST_SIZE   = 21'd12;
	localparam logic [20:0] HAVE_SIZE      = 21'd4;
	localparam logic [20:0] PIECE_MIN_SIZE = 21'd8;
	localparam logic [19:0] WORD_BYTES     = 20'd12;

	// Peer-wire message type numbers
	localparam logic [7:0] TYPE_HAVE    = 8'd4;
	localparam logic [7:0] TYPE_REQUEST = 8'd6;
	localparam logic [7:0] TYPE_PIECE   = 8'd7;

	// Event codes, as carried on the result tuser
	localparam logic [1:0] EV_KEEPALIVE = 2'd0;
	localparam logic [1:0] EV_HEADER    = 2'd1;
	localparam logic [1:0] EV_PAYLOAD   = 2'd2;
	localparam logic [1:0] EV_OVERSIZE  = 2'd3;

	// Classified beat passed from the front end to the back end
	typedef struct packed {
		logic [1:0]  kind;
		logic        last;
		logic [7:0]  data;
		logic [20:0] length;
		logic [19:0] offset;
	} lpmd_cmd_t;

endpackage
`default_nettype wire

@@ design/length_prefixed_message_deframer_top.sv @@
// A result passes through the queue and then the output register before it shows on m_axis.
// Throughput: one byte per cycle, sustained while the result side keeps taking beats.
// A two-entry queue between byte classification and result forming absorbs stalls.
// Reset: arst_n low clears all control state and sets the frame limit to 1048576.
// After an oversize error the block drops every byte until the next reset.
`default_nettype none
module length_prefixed_message_deframer_top (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           cfg_wen,
	input  wire  [20:0]   cfg_wdata,
	input  wire           s_axis_tvalid,
	output logic          s_axis_tready,
	input  wire  [7:0]    s_axis_tdata,   // [7:0] data_byte
	output logic          m_axis_tvalid,
	input  wire           m_axis_tready,
	output logic [159:0]  m_axis_tdata,   // msg_type, frame_length, byte_offset,
	                                      // payload_byte, word_first, word_second,
	                                      // word_third, size_ok, zero fill
	output logic [1:0]    m_axis_tuser,   // [1:0] event_res
	output logic          m_axis_tlast    // last
);
	import lpmd_pkg::*;

	logic       push;
	lpmd_cmd_t  push_cmd;
	logic       q_full;
	logic       q_empty;
	logic       pop;
	lpmd_cmd_t  head_cmd;

	logic [7:0]  o_type;
	logic [20:0] o_length;
	logic [19:0] o_offset;
	logic [7:0]  o_byte;
	logic [31:0] o_word0;
	logic [31:0] o_word1;
	logic [31:0] o_word2;
	logic        o_size_ok;

	lpmd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.push      (push),
		.push_cmd  (push_cmd),
		.q_full    (q_full)
	);

	lpmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head_cmd (head_cmd)
	);

	lpmd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.head_cmd    (head_cmd),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_event   (m_axis_tuser),
		.out_last    (m_axis_tlast),
		.out_type    (o_type),
		.out_length  (o_length),
		.out_offset  (o_offset),
		.out_byte    (o_byte),
		.out_word0   (o_word0),
		.out_word1   (o_word1),
		.out_word2   (o_word2),
		.out_size_ok (o_size_ok)
	);

	// Pack result fields, first field lowest
	assign m_axis_tdata = {6'd0, o_size_ok, o_word2, o_word1, o_word0,
		o_byte, o_offset, o_length, o_type};

endmodule
`default_nettype wire

@@ design/lpmd_front.sv @@
`default_nettype none
module lpmd_front (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_wen,
	input  wire  [20:0]            cfg_wdata,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire  [7:0]             in_byte,
	output logic                   push,
	output lpmd_pkg::lpmd_cmd_t    push_cmd,
	input  wire                    q_full
);
	import lpmd_pkg::*;

	localparam logic [1:0] PH_LENGTH  = 2'd0;
	localparam logic [1:0] PH_TYPE    = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;
	localparam logic [1:0] PH_HALTED  = 2'd3;

	logic [1:0]  phase_q;
	logic [23:0] shift_q;
	logic [1:0]  count_q;
	logic [20:0] len_q;
	logic [19:0] pos_q;
	logic [20:0] limit_q;

	logic        take;
	logic [31:0] full_len;
	logic [20:0] limit_eff;
	logic        pay_last;

	assign in_ready  = !q_full;
	assign take      = in_valid && in_ready;
	assign full_len  = {shift_q, in_byte};
	assign limit_eff = (limit_q > LIMIT_CAP) ? LIMIT_CAP : limit_q;
	assign pay_last  = ({1'b0, pos_q} + 21'd2) >= len_q;

	// Classify the accepted beat
	always_comb begin
		push     = 1'b0;
		push_cmd = '0;
		if (take) begin
			unique case (phase_q)
				PH_LENGTH: begin
					if (count_q == 2'd3) begin
						if (full_len == 32'd0) begin
							push          = 1'b1;
							push_cmd.kind = EV_KEEPALIVE;
							push_cmd.last = 1'b1;
						end else if (full_len > {11'd0, limit_eff}) begin
							push          = 1'b1;
							push_cmd.kind = EV_OVERSIZE;
						end
					end
				end
				PH_TYPE: begin
					push            = 1'b1;
					push_cmd.kind   = EV_HEADER;
					push_cmd.data   = in_byte;
					push_cmd.length = len_q;
					push_cmd.last   = (len_q <= 21'd1);
				end
				PH_PAYLOAD: begin
					push            = 1'b1;
					push_cmd.kind   = EV_PAYLOAD;
					push_cmd.data   = in_byte;
					push_cmd.length = len_q;
					push_cmd.offset = pos_q;
					push_cmd.last   = pay_last;
				end
				PH_HALTED: begin
					push = 1'b0;
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	// Limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_CAP;
		end else if (cfg_wen) begin
			limit_q <= cfg_wdata;
		end
	end

	// Frame tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LENGTH;
			shift_q <= '0;
			count_q <= '0;
			len_q   <= '0;
			pos_q   <= '0;
		end else if (take) begin
			unique case (phase_q)
				PH_LENGTH: begin
					if (count_q != 2'd3) begin
						shift_q <= full_len[23:0];
						count_q <= count_q + 2'd1;
					end else begin
						shift_q <= '0;
						count_q <= '0;
						if (full_len == 32'd0) begin
							phase_q <= PH_LENGTH;
						end else if (full_len > {11'd0, limit_eff}) begin
							phase_q <= PH_HALTED;
						end else begin
							len_q   <= full_len[20:0];
							phase_q <= PH_TYPE;
						end
					end
				end
				PH_TYPE: begin
					pos_q   <= '0;
					phase_q <= (len_q <= 21'd1) ? PH_LENGTH : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					if (pay_last) begin
						pos_q   <= '0;
						phase_q <= PH_LENGTH;
					end else begin
						pos_q <= pos_q + 20'd1;
					end
				end
				PH_HALTED: begin
					phase_q <= PH_HALTED;
				end
				default: begin
					phase_q <= PH_LENGTH;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ design/lpmd_queue.sv @@
`default_nettype none
module lpmd_queue (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  lpmd_pkg::lpmd_cmd_t    push_cmd,
	output logic                   full,
	input  wire                    pop,
	output logic                   empty,
	output lpmd_pkg::lpmd_cmd_t    head_cmd
);
	import lpmd_pkg::*;

	lpmd_cmd_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign head_cmd = entry_q[rd_ptr_q];

	// Two-entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

@@ design/lpmd_back.sv @@
`default_nettype none
module lpmd_back (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    q_empty,
	input  lpmd_pkg::lpmd_cmd_t    head_cmd,
	output logic                   pop,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [1:0]             out_event,
	output logic                   out_last,
	output logic [7:0]             out_type,
	output logic [20:0]            out_length,
	output logic [19:0]            out_offset,
	output logic [7:0]             out_byte,
	output logic [31:0]            out_word0,
	output logic [31:0]            out_word1,
	output logic [31:0]            out_word2,
	output logic                   out_size_ok
);
	import lpmd_pkg::*;

	logic        valid_q;
	logic [7:0]  type_q;
	logic [31:0] words_q [3];

	logic [31:0] words_nx [3];
	logic [7:0]  eff_type;
	logic [20:0] pay_size;
	logic        rule_ok;

	assign out_valid = valid_q;
	assign pop       = !q_empty && (!valid_q || out_ready);
	assign eff_type  = (head_cmd.kind == EV_HEADER) ? head_cmd.data : type_q;
	assign pay_size  = head_cmd.length - 21'd1;

	// Size rule per message type
	always_comb begin
		case (eff_type)
			TYPE_REQUEST: rule_ok = (pay_size == REQUEST_SIZE);
			TYPE_HAVE:    rule_ok = (pay_size == HAVE_SIZE);
			TYPE_PIECE:   rule_ok = (pay_size >= PIECE_MIN_SIZE);
			default:      rule_ok = 1'b1;
		endcase
	end

	// Word capture: header clears, early payload bytes land big-endian
	always_comb begin
		for (int w = 0; w < 3; w++) begin
			if (head_cmd.kind == EV_HEADER) begin
				words_nx[w] = '0;
			end else begin
				words_nx[w] = words_q[w];
				for (int l = 0; l < 4; l++) begin
					if (head_cmd.kind == EV_PAYLOAD && head_cmd.offset < WORD_BYTES &&
						head_cmd.offset[3:2] == 2'(w) &&
						head_cmd.offset[1:0] == 2'(3 - l)) begin
						words_nx[w][8*l +: 8] = head_cmd.data;
					end
				end
			end
		end
	end

	// Frame context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q     <= '0;
			words_q[0] <= '0;
			words_q[1] <= '0;
			words_q[2] <= '0;
		end else if (pop) begin
			if (head_cmd.kind == EV_HEADER) begin
				type_q <= head_cmd.data;
			end
			words_q[0] <= words_nx[0];
			words_q[1] <= words_nx[1];
			words_q[2] <= words_nx[2];
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			out_event   <= head_cmd.kind;
			out_last    <= head_cmd.last;
			out_type    <= '0;
			out_length  <= '0;
			out_offset  <= '0;
			out_byte    <= '0;
			out_word0   <= '0;
			out_word1   <= '0;
			out_word2   <= '0;
			out_size_ok <= 1'b0;
			if (head_cmd.kind == EV_HEADER || head_cmd.kind == EV_PAYLOAD) begin
				out_type   <= eff_type;
				out_length <= head_cmd.length;
				if (head_cmd.kind == EV_PAYLOAD) begin
					out_offset <= head_cmd.offset;
					out_byte   <= head_cmd.data;
				end
				if (head_cmd.last) begin
					out_word0   <= words_nx[0];
					out_word1   <= words_nx[1];
					out_word2   <= words_nx[2];
					out_size_ok <= rule_ok;
				end
			end
		end
	end

endmodule
`default_nettype wire
